/* rtl/core/mlr_pkg.sv */
// Shared types and constants for the midpoint line rasterizer.
package mlr_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int COLOR_WIDTH     = 24;

    typedef enum logic {
        ACT_START = 1'b0,
        ACT_STEP  = 1'b1
    } action_t;

    // Line control flags kept between steps.
    typedef struct packed {
        logic active;
        logic steep;
        logic minor_neg;
    } line_flags_t;

endpackage

/* rtl/core/mlr_cmd_if.sv */
// Command channel: start or step item carrying endpoints and color.
interface mlr_cmd_if
    import mlr_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic                          action;
    logic signed [COORD_WIDTH-1:0] x_start;
    logic signed [COORD_WIDTH-1:0] y_start;
    logic signed [COORD_WIDTH-1:0] x_end;
    logic signed [COORD_WIDTH-1:0] y_end;
    logic        [COLOR_WIDTH-1:0] line_color;

    modport source (
        output valid, action, x_start, y_start, x_end, y_end, line_color,
        input  ready
    );

    modport sink (
        input  valid, action, x_start, y_start, x_end, y_end, line_color,
        output ready
    );
endinterface

/* rtl/core/mlr_pix_if.sv */
// Pixel channel: one result per command.
interface mlr_pix_if
    import mlr_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic                          pixel_valid;
    logic signed [COORD_WIDTH-1:0] pixel_x;
    logic signed [COORD_WIDTH-1:0] pixel_y;
    logic        [COLOR_WIDTH-1:0] pixel_color;
    logic                          last_pixel;

    modport source (
        output valid, pixel_valid, pixel_x, pixel_y, pixel_color, last_pixel,
        input  ready
    );

    modport sink (
        input  valid, pixel_valid, pixel_x, pixel_y, pixel_color, last_pixel,
        output ready
    );
endinterface

/* rtl/core/mlr_step.sv */
// Line setup and one midpoint step: next line state and the pixel it emits.
module mlr_step
    import mlr_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    localparam int DW = COORD_WIDTH + 4,
    localparam int IW = COORD_WIDTH + 3
) (
    input  logic                          action,
    input  logic signed [COORD_WIDTH-1:0] x_start,
    input  logic signed [COORD_WIDTH-1:0] y_start,
    input  logic signed [COORD_WIDTH-1:0] x_end,
    input  logic signed [COORD_WIDTH-1:0] y_end,
    input  logic        [COLOR_WIDTH-1:0] line_color,

    input  line_flags_t                   flags,
    input  logic        [COORD_WIDTH-1:0] cur_x,
    input  logic        [COORD_WIDTH-1:0] cur_y,
    input  logic        [COORD_WIDTH-1:0] major_end,
    input  logic signed [DW-1:0]          decision,
    input  logic signed [IW-1:0]          inc_straight,
    input  logic signed [IW-1:0]          inc_diagonal,
    input  logic        [COLOR_WIDTH-1:0] held_color,

    output line_flags_t                   flags_next,
    output logic        [COORD_WIDTH-1:0] cur_x_next,
    output logic        [COORD_WIDTH-1:0] cur_y_next,
    output logic        [COORD_WIDTH-1:0] major_end_next,
    output logic signed [DW-1:0]          decision_next,
    output logic signed [IW-1:0]          inc_straight_next,
    output logic signed [IW-1:0]          inc_diagonal_next,
    output logic        [COLOR_WIDTH-1:0] held_color_next,

    output logic                          pixel_valid,
    output logic signed [COORD_WIDTH-1:0] pixel_x,
    output logic signed [COORD_WIDTH-1:0] pixel_y,
    output logic        [COLOR_WIDTH-1:0] pixel_color,
    output logic                          last_pixel
);

    localparam int EW = COORD_WIDTH + 1;

    // start setup
    logic signed [EW-1:0]          ddx, ddy;
    logic        [COORD_WIDTH-1:0] adx, ady, dmaj, dmin;
    logic                          x_major, swap;
    logic signed [COORD_WIDTH-1:0] x0, y0, x1, y1;
    logic signed [DW-1:0]          d_init;
    logic signed [IW-1:0]          is_init, id_init;
    logic        [COORD_WIDTH-1:0] st_major_end;
    logic                          st_minor_neg, st_last;

    // step
    logic                          diag;
    logic        [COORD_WIDTH-1:0] minor_delta;
    logic        [COORD_WIDTH-1:0] sx, sy;
    logic signed [IW-1:0]          inc_sel;
    logic                          sp_last;

    always_comb
    begin
        ddx = EW'(x_end) - EW'(x_start);
        ddy = EW'(y_end) - EW'(y_start);
        // magnitude of a full-width difference always fits in COORD_WIDTH bits
        adx = ddx[EW-1] ? COORD_WIDTH'(-ddx) : ddx[COORD_WIDTH-1:0];
        ady = ddy[EW-1] ? COORD_WIDTH'(-ddy) : ddy[COORD_WIDTH-1:0];

        x_major = (adx >= ady);
        swap    = x_major ? (x_start > x_end) : (y_start > y_end);
        x0 = swap ? x_end   : x_start;
        y0 = swap ? y_end   : y_start;
        x1 = swap ? x_start : x_end;
        y1 = swap ? y_start : y_end;

        dmaj = x_major ? adx : ady;
        dmin = x_major ? ady : adx;
        st_minor_neg = x_major ? !(y0 < y1) : !(x0 < x1);
        st_major_end = x_major ? x1 : y1;
        st_last      = x_major ? (x0 == x1) : (y0 == y1);

        d_init  = $signed({4'b0, dmaj}) - $signed({3'b0, dmin, 1'b0});
        is_init = IW'(0) - $signed({2'b0, dmin, 1'b0});
        id_init = $signed({2'b0, dmaj, 1'b0}) - $signed({2'b0, dmin, 1'b0});
    end

    always_comb
    begin
        diag        = decision[DW-1];
        minor_delta = flags.minor_neg ? '1 : COORD_WIDTH'(1);
        if (flags.steep)
        begin
            sy = cur_y + COORD_WIDTH'(1);
            sx = diag ? cur_x + minor_delta : cur_x;
        end
        else
        begin
            sx = cur_x + COORD_WIDTH'(1);
            sy = diag ? cur_y + minor_delta : cur_y;
        end
        inc_sel = diag ? inc_diagonal : inc_straight;
        sp_last = (flags.steep ? sy : sx) == major_end;
    end

    always_comb
    begin
        flags_next        = flags;
        cur_x_next        = cur_x;
        cur_y_next        = cur_y;
        major_end_next    = major_end;
        decision_next     = decision;
        inc_straight_next = inc_straight;
        inc_diagonal_next = inc_diagonal;
        held_color_next   = held_color;
        pixel_valid       = 1'b0;
        pixel_x           = '0;
        pixel_y           = '0;
        pixel_color       = '0;
        last_pixel        = 1'b0;

        if (action == ACT_START)
        begin
            flags_next.active    = !st_last;
            flags_next.steep     = !x_major;
            flags_next.minor_neg = st_minor_neg;
            cur_x_next        = x0;
            cur_y_next        = y0;
            major_end_next    = st_major_end;
            decision_next     = d_init;
            inc_straight_next = is_init;
            inc_diagonal_next = id_init;
            held_color_next   = line_color;
            pixel_valid       = 1'b1;
            pixel_x           = x0;
            pixel_y           = y0;
            pixel_color       = line_color;
            last_pixel        = st_last;
        end
        else if (flags.active)
        begin
            flags_next.active = !sp_last;
            cur_x_next        = sx;
            cur_y_next        = sy;
            decision_next     = decision + DW'(inc_sel);
            pixel_valid       = 1'b1;
            pixel_x           = sx;
            pixel_y           = sy;
            pixel_color       = held_color;
            last_pixel        = sp_last;
        end
    end

endmodule

/* rtl/core/midpoint_line_rasterizer.sv */
// Top level of the midpoint line rasterizer: command register, step logic, pixel register.
//
//  channel | dir | payload
//  --------+-----+---------------------------------------------------------
//  cmd     | in  | action, x_start, y_start, x_end, y_end, line_color
//  pix     | out | pixel_valid, pixel_x, pixel_y, pixel_color, last_pixel
//
// One command per clock while pix does not stall; each command gives exactly one pixel
// transfer, after passing through the command register and then the pixel register.
// The only loop is the decision/coordinate update, one add and compare per step.
// Reset clears the line state and both stage valids; no line is active.
// A stall on pix holds the pixel register and then the command register;
// cmd.ready drops only once both are full.
module midpoint_line_rasterizer
    import mlr_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    mlr_cmd_if.sink   cmd,
    mlr_pix_if.source pix
);

    localparam int DW = COORD_WIDTH + 4;
    localparam int IW = COORD_WIDTH + 3;

    // command register
    logic                          c_valid_reg;
    logic                          c_action_reg;
    logic signed [COORD_WIDTH-1:0] c_xs_reg, c_ys_reg, c_xe_reg, c_ye_reg;
    logic        [COLOR_WIDTH-1:0] c_color_reg;

    // line state
    line_flags_t                   flags_reg, flags_next;
    logic        [COORD_WIDTH-1:0] cur_x_reg, cur_x_next;
    logic        [COORD_WIDTH-1:0] cur_y_reg, cur_y_next;
    logic        [COORD_WIDTH-1:0] major_end_reg, major_end_next;
    logic signed [DW-1:0]          decision_reg, decision_next;
    logic signed [IW-1:0]          inc_straight_reg, inc_straight_next;
    logic signed [IW-1:0]          inc_diagonal_reg, inc_diagonal_next;
    logic        [COLOR_WIDTH-1:0] held_color_reg, held_color_next;

    // pixel register
    logic                          p_valid_reg;
    logic                          p_pv_reg, p_pv_next;
    logic signed [COORD_WIDTH-1:0] p_x_reg, p_x_next;
    logic signed [COORD_WIDTH-1:0] p_y_reg, p_y_next;
    logic        [COLOR_WIDTH-1:0] p_color_reg, p_color_next;
    logic                          p_last_reg, p_last_next;

    logic advance;
    logic cmd_take;

    assign advance   = !p_valid_reg || pix.ready;
    assign cmd.ready = !c_valid_reg || advance;
    assign cmd_take  = cmd.valid && cmd.ready;

    mlr_step #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_step (
        .action            (c_action_reg),
        .x_start           (c_xs_reg),
        .y_start           (c_ys_reg),
        .x_end             (c_xe_reg),
        .y_end             (c_ye_reg),
        .line_color        (c_color_reg),
        .flags             (flags_reg),
        .cur_x             (cur_x_reg),
        .cur_y             (cur_y_reg),
        .major_end         (major_end_reg),
        .decision          (decision_reg),
        .inc_straight      (inc_straight_reg),
        .inc_diagonal      (inc_diagonal_reg),
        .held_color        (held_color_reg),
        .flags_next        (flags_next),
        .cur_x_next        (cur_x_next),
        .cur_y_next        (cur_y_next),
        .major_end_next    (major_end_next),
        .decision_next     (decision_next),
        .inc_straight_next (inc_straight_next),
        .inc_diagonal_next (inc_diagonal_next),
        .held_color_next   (held_color_next),
        .pixel_valid       (p_pv_next),
        .pixel_x           (p_x_next),
        .pixel_y           (p_y_next),
        .pixel_color       (p_color_next),
        .last_pixel        (p_last_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            c_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            c_action_reg <= cmd.action;
            c_xs_reg     <= cmd.x_start;
            c_ys_reg     <= cmd.y_start;
            c_xe_reg     <= cmd.x_end;
            c_ye_reg     <= cmd.y_end;
            c_color_reg  <= cmd.line_color;
        end
    end

    // state advances only when the command moves into the pixel register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg        <= '0;
            cur_x_reg        <= '0;
            cur_y_reg        <= '0;
            major_end_reg    <= '0;
            decision_reg     <= '0;
            inc_straight_reg <= '0;
            inc_diagonal_reg <= '0;
            held_color_reg   <= '0;
            p_valid_reg      <= 1'b0;
        end
        else if (advance)
        begin
            p_valid_reg <= c_valid_reg;
            if (c_valid_reg)
            begin
                flags_reg        <= flags_next;
                cur_x_reg        <= cur_x_next;
                cur_y_reg        <= cur_y_next;
                major_end_reg    <= major_end_next;
                decision_reg     <= decision_next;
                inc_straight_reg <= inc_straight_next;
                inc_diagonal_reg <= inc_diagonal_next;
                held_color_reg   <= held_color_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && c_valid_reg)
        begin
            p_pv_reg    <= p_pv_next;
            p_x_reg     <= p_x_next;
            p_y_reg     <= p_y_next;
            p_color_reg <= p_color_next;
            p_last_reg  <= p_last_next;
        end
    end

    assign pix.valid       = p_valid_reg;
    assign pix.pixel_valid = p_pv_reg;
    assign pix.pixel_x     = p_x_reg;
    assign pix.pixel_y     = p_y_reg;
    assign pix.pixel_color = p_color_reg;
    assign pix.last_pixel  = p_last_reg;

endmodule
